// File: rtl/core/gbs_pkg.sv
// ----------------------------------------------------------------------------
// Grid bilinear sampler package
// Shared constants, register map and request codes of the grid sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

  localparam int CELL_AW  = 6;
  localparam int BANK_AW  = 2 * (CELL_AW - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int VAL_W    = 16;
  localparam int MAX_DIM  = 1 << CELL_AW;
  localparam int DIM_W    = CELL_AW + 1;
  localparam int PADDR_W  = 5;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_INV_CELL  = 3'd2;
  localparam logic [2:0] REG_GRID_W    = 3'd3;
  localparam logic [2:0] REG_GRID_H    = 3'd4;
  localparam logic [2:0] REG_Z_MIN     = 3'd5;
  localparam logic [2:0] REG_Z_MAX     = 3'd6;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 48;

endpackage

`default_nettype wire

// File: rtl/core/grid_bilinear_sampler_core.sv
// ----------------------------------------------------------------------------
// Grid bilinear sampler core
// Cell grid with nearest and bilinear sampling of world points.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock cycle unless the result side stalls,
// writes and samples in any order, and returns sample results via stages a to f.
// The grid is held in four memory banks selected by the parity of the cell
// column and row, so the four corners of a blend are read in the same cycle;
// writes go to the banks at the same pipeline stage where samples read, which
// keeps every sample ordered against the writes around it. The only stall
// comes from the result side: a two-entry output buffer absorbs one held
// result before the input is held.
`default_nettype none

module grid_bilinear_sampler_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Fields from bit 0: write_x, write_y, write_value, query_x, query_y,
  // query_z, zero padding.
  input  wire logic [gbs_pkg::IN_DATA_W-1:0] s_tdata,
  // Fields from bit 0: req_type.
  input  wire logic                          s_tuser,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: nearest_x, nearest_y, nearest_value, blended_value,
  // zero padding.
  output logic [gbs_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Fields from bit 0: sample_valid.
  output logic                               m_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gbs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  import gbs_pkg::*;

  function automatic logic signed [VAL_W-1:0] lerp_q16(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b,
    input logic        [15:0]      t
  );
    logic signed [VAL_W:0]    diff;
    logic signed [VAL_W+17:0] prod;
    logic signed [VAL_W+17:0] adj;
    diff = {b[VAL_W-1], b} - {a[VAL_W-1], a};
    prod = diff * $signed({1'b0, t});
    adj  = prod + (prod[VAL_W+17] ? (VAL_W+18)'(65535) : (VAL_W+18)'(0));
    adj  = adj >>> 16;
    return a + adj[VAL_W-1:0];
  endfunction

  // Configuration registers.
  logic [31:0]      origin_x, origin_y, inv_cell_size, z_minimum, z_maximum;
  logic [DIM_W-1:0] grid_width, grid_height;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      inv_cell_size <= 32'h0100_0000;
      grid_width    <= DIM_W'(1);
      grid_height   <= DIM_W'(1);
      z_minimum     <= 32'h8000_0000;
      z_maximum     <= 32'h7FFF_FFFF;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:2])
        REG_ORIGIN_X: origin_x      <= pwdata;
        REG_ORIGIN_Y: origin_y      <= pwdata;
        REG_INV_CELL: inv_cell_size <= pwdata;
        REG_GRID_W:   grid_width    <= pwdata[DIM_W-1:0];
        REG_GRID_H:   grid_height   <= pwdata[DIM_W-1:0];
        REG_Z_MIN:    z_minimum     <= pwdata;
        REG_Z_MAX:    z_maximum     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_ORIGIN_X: prdata = origin_x;
      REG_ORIGIN_Y: prdata = origin_y;
      REG_INV_CELL: prdata = inv_cell_size;
      REG_GRID_W:   prdata = 32'(grid_width);
      REG_GRID_H:   prdata = 32'(grid_height);
      REG_Z_MIN:    prdata = z_minimum;
      REG_Z_MAX:    prdata = z_maximum;
      default:      prdata = '0;
    endcase
  end

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [CELL_AW-1:0] w_m1, h_m1;

  always_comb begin
    w_eff = grid_width;
    h_eff = grid_height;
    if (grid_width == '0) w_eff = DIM_W'(1);
    else if (grid_width > DIM_W'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
    if (grid_height == '0) h_eff = DIM_W'(1);
    else if (grid_height > DIM_W'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
  end

  assign w_m1 = CELL_AW'(w_eff - DIM_W'(1));
  assign h_m1 = CELL_AW'(h_eff - DIM_W'(1));

  // Pipeline control and output buffer.
  logic adv, in_fire;
  logic skid_valid;

  assign adv      = ~skid_valid;
  assign s_tready = adv;
  assign in_fire  = s_tvalid & s_tready;

  // Input field unpacking.
  logic [CELL_AW-1:0]       in_wx, in_wy;
  logic [VAL_W-1:0]         in_wval;
  logic signed [31:0]       in_qx, in_qy, in_qz;
  logic signed [32:0]       dx_full, dy_full;

  assign in_wx   = s_tdata[5:0];
  assign in_wy   = s_tdata[11:6];
  assign in_wval = s_tdata[27:12];
  assign in_qx   = s_tdata[59:28];
  assign in_qy   = s_tdata[91:60];
  assign in_qz   = s_tdata[123:92];
  assign dx_full = {in_qx[31], in_qx} - {origin_x[31], origin_x};
  assign dy_full = {in_qy[31], in_qy} - {origin_y[31], origin_y};

  // Stage a: offsets from the grid corner and Z test.
  logic               a_valid, a_type, a_ok;
  logic [31:0]        a_dx, a_dy;
  logic [CELL_AW-1:0] a_wx, a_wy;
  logic [VAL_W-1:0]   a_wval;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_type <= s_tuser;
      a_dx   <= dx_full[31:0];
      a_dy   <= dy_full[31:0];
      a_ok   <= ~dx_full[32] & ~dy_full[32] & (in_qz >= $signed(z_minimum))
                & (in_qz <= $signed(z_maximum));
      a_wx   <= in_wx;
      a_wy   <= in_wy;
      a_wval <= in_wval;
    end
  end

  // Stage b: scale to grid cells.
  logic               b_valid, b_type, b_ok;
  logic [63:0]        b_px, b_py;
  logic [CELL_AW-1:0] b_wx, b_wy;
  logic [VAL_W-1:0]   b_wval;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_type <= a_type;
      b_ok   <= a_ok;
      b_px   <= a_dx * inv_cell_size;
      b_py   <= a_dy * inv_cell_size;
      b_wx   <= a_wx;
      b_wy   <= a_wy;
      b_wval <= a_wval;
    end
  end

  // Stage c: cell indices, corners and blend weights.
  logic [39:0]        pos_x, pos_y;
  logic [40:0]        g_x, g_y;
  logic               gneg_x, gneg_y;
  logic [CELL_AW-1:0] x0_n, x1_n, y0_n, y1_n, cx_n, cy_n;

  assign pos_x  = b_px[63:24];
  assign pos_y  = b_py[63:24];
  assign g_x    = {1'b0, pos_x} - 41'd32768;
  assign g_y    = {1'b0, pos_y} - 41'd32768;
  assign gneg_x = g_x[40];
  assign gneg_y = g_y[40];

  always_comb begin
    if (gneg_x) begin
      x0_n = '0;
      x1_n = '0;
    end else if (g_x[39:16] >= 24'(w_m1)) begin
      x0_n = w_m1;
      x1_n = w_m1;
    end else begin
      x0_n = g_x[16 +: CELL_AW];
      x1_n = g_x[16 +: CELL_AW] + CELL_AW'(1);
    end
    if (gneg_y) begin
      y0_n = '0;
      y1_n = '0;
    end else if (g_y[39:16] >= 24'(h_m1)) begin
      y0_n = h_m1;
      y1_n = h_m1;
    end else begin
      y0_n = g_y[16 +: CELL_AW];
      y1_n = g_y[16 +: CELL_AW] + CELL_AW'(1);
    end
    cx_n = (pos_x[39:16] >= 24'(w_m1)) ? w_m1 : pos_x[16 +: CELL_AW];
    cy_n = (pos_y[39:16] >= 24'(h_m1)) ? h_m1 : pos_y[16 +: CELL_AW];
  end

  logic               c_valid, c_type, c_in;
  logic [CELL_AW-1:0] c_x0, c_x1, c_y0, c_y1, c_cx, c_cy;
  logic [15:0]        c_ax, c_ay;
  logic               c_selx, c_sely;
  logic [CELL_AW-1:0] c_wx, c_wy;
  logic [VAL_W-1:0]   c_wval;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_type <= b_type;
      c_in   <= b_ok & (pos_x <= {17'd0, w_eff, 16'd0})
                & (pos_y <= {17'd0, h_eff, 16'd0});
      c_x0   <= x0_n;
      c_x1   <= x1_n;
      c_y0   <= y0_n;
      c_y1   <= y1_n;
      c_cx   <= cx_n;
      c_cy   <= cy_n;
      c_ax   <= pos_x[15:0] ^ 16'h8000;
      c_ay   <= pos_y[15:0] ^ 16'h8000;
      c_selx <= pos_x[15];
      c_sely <= pos_y[15];
      c_wx   <= b_wx;
      c_wy   <= b_wy;
      c_wval <= b_wval;
    end
  end

  // Banked cell store, bank index is {row parity, column parity}.
  logic [VAL_W-1:0] bank_rdata [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CELL_AW-1:0] rx, ry;
    logic               we, re;

    assign rx = (c_x0[0] == b[0]) ? c_x0 : c_x1;
    assign ry = (c_y0[0] == b[1]) ? c_y0 : c_y1;
    assign we = adv & c_valid & (c_type == REQ_WRITE)
                & (c_wx[0] == b[0]) & (c_wy[0] == b[1]);
    assign re = adv & c_valid & (c_type == REQ_SAMPLE);

    gbs_ram #(
      .WIDTH(VAL_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr({c_wy[CELL_AW-1:1], c_wx[CELL_AW-1:1]}),
      .wdata(c_wval),
      .re   (re),
      .raddr({ry[CELL_AW-1:1], rx[CELL_AW-1:1]}),
      .rdata(bank_rdata[b])
    );
  end

  // Stage d: memory data arrives.
  logic               d_valid, d_sample, d_in;
  logic               d_px0, d_px1, d_py0, d_py1, d_selx, d_sely;
  logic [CELL_AW-1:0] d_cx, d_cy;
  logic [15:0]        d_ax, d_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sample <= (c_type == REQ_SAMPLE);
      d_in     <= c_in;
      d_px0    <= c_x0[0];
      d_px1    <= c_x1[0];
      d_py0    <= c_y0[0];
      d_py1    <= c_y1[0];
      d_selx   <= c_selx;
      d_sely   <= c_sely;
      d_cx     <= c_cx;
      d_cy     <= c_cy;
      d_ax     <= c_ax;
      d_ay     <= c_ay;
    end
  end

  logic [VAL_W-1:0] v00, v10, v01, v11, v_near;

  assign v00    = bank_rdata[{d_py0, d_px0}];
  assign v10    = bank_rdata[{d_py0, d_px1}];
  assign v01    = bank_rdata[{d_py1, d_px0}];
  assign v11    = bank_rdata[{d_py1, d_px1}];
  assign v_near = bank_rdata[{d_sely ? d_py0 : d_py1, d_selx ? d_px0 : d_px1}];

  // Stage e: horizontal blends.
  logic               e_valid, e_sample, e_in;
  logic [CELL_AW-1:0] e_cx, e_cy;
  logic [15:0]        e_ay;
  logic [VAL_W-1:0]   e_top, e_bot, e_near;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid & d_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_sample <= d_sample;
      e_in     <= d_in;
      e_cx     <= d_cx;
      e_cy     <= d_cy;
      e_ay     <= d_ay;
      e_top    <= lerp_q16(v00, v10, d_ax);
      e_bot    <= lerp_q16(v01, v11, d_ax);
      e_near   <= v_near;
    end
  end

  // Stage f: vertical blend and result packing.
  logic                  f_valid;
  logic                  f_user;
  logic [OUT_DATA_W-1:0] f_data;
  logic [VAL_W-1:0]      blend_n;

  assign blend_n = lerp_q16(e_top, e_bot, e_ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid & e_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_user <= e_in;
      f_data <= e_in ? {OUT_DATA_W'({blend_n, e_near, e_cy, e_cx})} : '0;
    end
  end

  // Output register with one skid entry.
  logic                  res_fire;
  logic                  skid_user;
  logic [OUT_DATA_W-1:0] skid_data;

  assign res_fire = adv & f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (~m_tvalid | m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (~m_tvalid | m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= f_data;
        m_tuser <= f_user;
      end
    end else if (res_fire) begin
      skid_data <= f_data;
      skid_user <= f_user;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gbs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
